[rtl/esc_pkg.sv]
// Types, register indexes and arithmetic helpers for the sensor compensation pipeline.
package esc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRES_L = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_PRES_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_GAS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP      = 3'd5;

    // unsigned n / 100 == (n * magic) >> 37 for every 32-bit n
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int unsigned DIV100_SHIFT = 37;

    // working set carried down the pipeline; each stage fills in its own fields
    typedef struct packed {
        logic               gon;
        logic               gv;
        logic               hs;
        logic [19:0]        praw;
        logic [15:0]        hraw;
        logic [9:0]         graw;
        logic [3:0]         grange;
        logic signed [31:0] ta, tb, thh, tcm, tfine, temp, pa;
        logic signed [31:0] phh, pa5, pa2, pb1, pa3, pb, pav, pa2m, pcb, pcm;
        logic               pbig;
        logic               dz;
        logic [31:0]        pdv, pqd, prem;
        logic signed [31:0] m3, m4, m5, m7, d3, d4, d5, d7;
        logic signed [31:0] e1, e4, m55, d55, e2m, e3, e5m, e6m, hm, hum;
        logic [25:0]        g1;
        logic [27:0]        g2;
        logic               gz;
        logic [57:0]        gnm;
        logic [49:0]        gnum;
        logic [31:0]        gqd;
        logic [27:0]        grem;
        logic signed [31:0] pc, hh, bm, h8sq, am, pbq, c3, cm, pres;
        logic [31:0]        gohm;
    } work_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] pressure_pa;
        logic signed [31:0] humidity_milli;
        logic signed [31:0] gas_ohms;
        logic               gas_valid_out;
        logic               heater_stable_out;
    } res_t;

    function automatic logic signed [31:0] sx8(input logic [7:0] f);
        return 32'($signed(f));
    endfunction

    function automatic logic signed [31:0] sx16(input logic [15:0] f);
        return 32'($signed(f));
    endfunction

    function automatic logic signed [31:0] zx16(input logic [15:0] f);
        return $signed(32'(f));
    endfunction

    // truncating signed divide by 100
    function automatic logic signed [31:0] d100(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] q;
        mag  = v[31] ? (~v + 32'd1) : v;
        prod = 64'(mag) * 64'(DIV100_MAGIC);
        q    = 32'(prod[63:DIV100_SHIFT]);
        return v[31] ? $signed(~q + 32'd1) : $signed(q);
    endfunction

    function automatic logic [30:0] gas_tab_a(input logic [3:0] idx);
        logic [30:0] r;
        case (idx)
            4'd5:    r = 31'd2126008810;
            4'd7:    r = 31'd2130303777;
            4'd10:   r = 31'd2143188679;
            4'd11:   r = 31'd2136746228;
            4'd13:   r = 31'd2126008810;
            default: r = 31'd2147483647;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] gas_tab_b(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'd4096000000;
            4'd1:    r = 32'd2048000000;
            4'd2:    r = 32'd1024000000;
            4'd3:    r = 32'd512000000;
            4'd4:    r = 32'd255744255;
            4'd5:    r = 32'd127110228;
            4'd6:    r = 32'd64000000;
            4'd7:    r = 32'd32258064;
            4'd8:    r = 32'd16016016;
            4'd9:    r = 32'd8000000;
            4'd10:   r = 32'd4000000;
            4'd11:   r = 32'd2000000;
            4'd12:   r = 32'd1000000;
            4'd13:   r = 32'd500000;
            4'd14:   r = 32'd250000;
            default: r = 32'd125000;
        endcase
        return r;
    endfunction

endpackage

[rtl/env_sensor_compensation.sv]
// Integer compensation pipeline for temperature, pressure, humidity and gas readings.
//
//  channel  | prefix | handshake        | payload
//  ---------+--------+------------------+------------------------------------------
//  raw in   | s_     | s_valid/s_ready  | temperature, pressure, humidity, gas, flags
//  result   | m_     | m_valid/m_ready  | temperature, pressure, humidity, gas, flags
//  config   | cfg_   | cfg_wr_en        | cfg_index, cfg_wr_data (write only)
//
// One transaction per cycle sustained while the skid register is empty. The path to m_valid
// runs through 51 compute stages plus the output register, including the two 32-stage restoring
// dividers (pressure quotient, gas resistance), which run side by side, one quotient bit per stage.
// Reset (aresetn low, synchronous) clears the calibration registers, the stage valid
// bits and the output buffer. A result held by m_ready low moves into a skid register;
// the whole pipeline then holds until the skid register drains, so nothing is lost.
module env_sensor_compensation (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [19:0]                      s_temperature_raw,
    input  logic [19:0]                      s_pressure_raw,
    input  logic [15:0]                      s_humidity_raw,
    input  logic [9:0]                       s_gas_raw,
    input  logic [3:0]                       s_gas_range_index,
    input  logic                             s_gas_valid_in,
    input  logic                             s_heater_stable_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_temperature_centi,
    output logic signed [31:0]               m_pressure_pa,
    output logic signed [31:0]               m_humidity_milli,
    output logic signed [31:0]               m_gas_ohms,
    output logic                             m_gas_valid_out,
    output logic                             m_heater_stable_out
);
    import esc_pkg::*;

    localparam int unsigned DIV_N   = 32;
    localparam int unsigned ST_DIV0 = 15;
    localparam int unsigned ST_POST = ST_DIV0 + DIV_N;
    localparam int unsigned NST     = ST_POST + 4;
    localparam int unsigned LAST    = NST - 1;

    logic [39:0] cal_t_reg;
    logic [55:0] cal_pl_reg;
    logic [63:0] cal_ph_reg;
    logic [63:0] cal_h_reg;
    logic [15:0] cal_g_reg;
    logic [7:0]  setup_reg;

    logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, h7, rse;

    work_t          pipe_reg  [NST];
    work_t          pipe_next [NST];
    logic [NST-1:0] vld_reg;
    logic           adv;

    res_t out_reg, skid_reg, res_d;
    logic out_valid_reg, skid_valid_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t_reg  <= '0;
            cal_pl_reg <= '0;
            cal_ph_reg <= '0;
            cal_h_reg  <= '0;
            cal_g_reg  <= '0;
            setup_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CAL_TEMP:   cal_t_reg  <= cfg_wr_data[39:0];
                REG_CAL_PRES_L: cal_pl_reg <= cfg_wr_data[55:0];
                REG_CAL_PRES_H: cal_ph_reg <= cfg_wr_data;
                REG_CAL_HUM:    cal_h_reg  <= cfg_wr_data;
                REG_CAL_GAS:    cal_g_reg  <= cfg_wr_data[15:0];
                REG_SETUP:      setup_reg  <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign t1  = zx16(cal_t_reg[15:0]);
    assign t2  = sx16(cal_t_reg[31:16]);
    assign t3  = sx8(cal_t_reg[39:32]);
    assign p1  = zx16(cal_pl_reg[15:0]);
    assign p2  = sx16(cal_pl_reg[31:16]);
    assign p3  = sx8(cal_pl_reg[39:32]);
    assign p4  = sx16(cal_pl_reg[55:40]);
    assign p5  = sx16(cal_ph_reg[15:0]);
    assign p6  = sx8(cal_ph_reg[23:16]);
    assign p7  = sx8(cal_ph_reg[31:24]);
    assign p8  = sx16(cal_ph_reg[47:32]);
    assign p9  = sx16(cal_ph_reg[63:48]);
    assign h1  = zx16({4'd0, cal_h_reg[11:0]});
    assign h2  = zx16({4'd0, cal_h_reg[23:12]});
    assign h3  = sx8(cal_h_reg[31:24]);
    assign h4  = sx8(cal_h_reg[39:32]);
    assign h5  = sx8(cal_h_reg[47:40]);
    assign h6  = zx16({8'd0, cal_h_reg[55:48]});
    assign h7  = sx8(cal_h_reg[63:56]);
    assign rse = sx8(cal_g_reg[7:0]);
    assign p10 = zx16({8'd0, cal_g_reg[15:8]});

    // stage logic
    always_comb begin
        work_t              w;
        logic [19:0]        traw;
        logic [19:0]        praw;
        logic signed [31:0] gk;
        logic [41:0]        gprod;
        logic signed [31:0] pc;
        logic [32:0]        pr;
        logic [28:0]        gr;
        logic               qbit;

        // 0: input capture, oversampling shift, temperature offset
        w    = '0;
        traw = s_temperature_raw;
        praw = s_pressure_raw;
        if (setup_reg[6]) begin
            if (setup_reg[2:0] != 3'd0) traw = traw >> (setup_reg[2:0] - 3'd1);
            if (setup_reg[5:3] != 3'd0) praw = praw >> (setup_reg[5:3] - 3'd1);
        end
        w.gon    = setup_reg[7];
        w.gv     = setup_reg[7] & s_gas_valid_in;
        w.hs     = setup_reg[7] & s_heater_stable_in;
        w.praw   = praw;
        w.hraw   = s_humidity_raw;
        w.graw   = s_gas_raw;
        w.grange = s_gas_range_index;
        w.ta     = $signed(32'(traw[19:3])) - (t1 <<< 1);
        pipe_next[0] = w;

        // 1
        w     = pipe_reg[0];
        w.tb  = (w.ta * t2) >>> 11;
        w.thh = (w.ta >>> 1) * (w.ta >>> 1);
        gk    = 32'sd1340 + 32'sd5 * rse;   // always within 700..1975
        gprod = 42'(gk[10:0]) * 42'(gas_tab_a(w.grange));
        w.g1  = gprod[41:16];
        pipe_next[1] = w;

        // 2
        w     = pipe_reg[1];
        w.tcm = (w.thh >>> 12) * (t3 <<< 4);
        w.g2  = 28'({w.graw, 15'd0}) + 28'(w.g1) - 28'd16777216;
        w.gnm = 58'(gas_tab_b(w.grange)) * 58'(w.g1);
        pipe_next[2] = w;

        // 3
        w       = pipe_reg[2];
        w.tfine = w.tb + (w.tcm >>> 14);
        w.gnum  = 50'(w.gnm[57:9]) + 50'(w.g2[27:1]);
        w.gz    = (w.g2 == '0);
        pipe_next[3] = w;

        // 4
        w      = pipe_reg[3];
        w.temp = (w.tfine * 32'sd5 + 32'sd128) >>> 8;
        w.pa   = (w.tfine >>> 1) - 32'sd64000;
        pipe_next[4] = w;

        // 5
        w     = pipe_reg[4];
        w.phh = (w.pa >>> 2) * (w.pa >>> 2);
        w.pa5 = w.pa * p5;
        w.pa2 = p2 * w.pa;
        w.m3  = w.temp * h3;
        w.m4  = w.temp * h4;
        w.m5  = w.temp * h5;
        w.m7  = w.temp * h7;
        pipe_next[5] = w;

        // 6
        w     = pipe_reg[5];
        w.pb1 = (w.phh >>> 11) * p6;
        w.pa3 = (w.phh >>> 13) * (p3 <<< 5);
        w.d3  = d100(w.m3);
        w.d4  = d100(w.m4);
        w.d5  = d100(w.m5);
        w.d7  = d100(w.m7);
        pipe_next[6] = w;

        // 7
        w     = pipe_reg[6];
        w.pb  = ((((w.pb1 >>> 2) + (w.pa5 <<< 1)) >>> 2) + (p4 <<< 16));
        w.pav = ((w.pa3 >>> 3) + (w.pa2 >>> 1)) >>> 18;
        w.e1  = $signed(32'(w.hraw)) - (h1 <<< 4) - (w.d3 >>> 1);
        w.m55 = w.temp * w.d5;
        w.e4  = ((h6 <<< 7) + w.d7) >>> 4;
        pipe_next[7] = w;

        // 8
        w      = pipe_reg[7];
        w.pa2m = (32'sd32768 + w.pav) * p1;
        w.pcb  = 32'sd1048576 - $signed(32'(w.praw)) - (w.pb >>> 12);
        w.d55  = d100(w.m55 >>> 6);
        pipe_next[8] = w;

        // 9
        w     = pipe_reg[8];
        w.pdv = w.pa2m >>> 15;
        w.pcm = w.pcb * 32'sd3125;
        w.e2m = h2 * (w.d4 + w.d55 + 32'sd16384);
        pipe_next[9] = w;

        // 10: dividend set-up; large values are divided first and doubled after
        w      = pipe_reg[9];
        w.pbig = !w.pcm[31] && w.pcm[30];
        w.pqd  = w.pbig ? w.pcm : {w.pcm[30:0], 1'b0};
        w.dz   = (w.pdv == '0);
        w.e3   = w.e1 * (w.e2m >>> 10);
        pipe_next[10] = w;

        // 11..14: humidity tail, with the divider set-up in 14
        w     = pipe_reg[10];
        w.e5m = (w.e3 >>> 14) * (w.e3 >>> 14);
        pipe_next[11] = w;

        w     = pipe_reg[11];
        w.e6m = w.e4 * (w.e5m >>> 10);
        pipe_next[12] = w;

        w    = pipe_reg[12];
        w.hm = ((w.e3 + (w.e6m >>> 1)) >>> 10) * 32'sd1000;
        pipe_next[13] = w;

        w      = pipe_reg[13];
        w.hum  = w.hm >>> 12;
        w.prem = '0;
        // gas quotient fits 32 bits, so the top dividend bits start as remainder
        w.grem = 28'(w.gnum[49:32]);
        w.gqd  = w.gnum[31:0];
        pipe_next[14] = w;

        // restoring dividers, one quotient bit per stage
        for (int k = 0; k < DIV_N; k++) begin
            w      = pipe_reg[ST_DIV0 + k - 1];
            pr     = {w.prem, w.pqd[31]};
            qbit   = (pr >= {1'b0, w.pdv});
            w.prem = qbit ? (pr[31:0] - w.pdv) : pr[31:0];
            w.pqd  = {w.pqd[30:0], qbit};
            gr     = {w.grem, w.gqd[31]};
            qbit   = (gr >= 29'(w.g2));
            w.grem = qbit ? (gr[27:0] - w.g2) : gr[27:0];
            w.gqd  = {w.gqd[30:0], qbit};
            pipe_next[ST_DIV0 + k] = w;
        end

        // post-division pressure correction
        w      = pipe_reg[ST_POST - 1];
        pc     = w.dz ? '0 : (w.pbig ? $signed({w.pqd[30:0], 1'b0}) : $signed(w.pqd));
        w.pc   = pc;
        w.hh   = (pc >>> 3) * (pc >>> 3);
        w.bm   = (pc >>> 2) * p8;
        w.h8sq = (pc >>> 8) * (pc >>> 8);
        w.gohm = (w.gon && !w.gz) ? w.gqd : '0;
        pipe_next[ST_POST] = w;

        w     = pipe_reg[ST_POST];
        w.am  = p9 * (w.hh >>> 13);
        w.pbq = w.bm >>> 13;
        w.c3  = w.h8sq * (w.pc >>> 8);
        pipe_next[ST_POST + 1] = w;

        w    = pipe_reg[ST_POST + 1];
        w.am = w.am >>> 12;
        w.cm = w.c3 * p10;
        pipe_next[ST_POST + 2] = w;

        w      = pipe_reg[ST_POST + 2];
        w.pres = w.pc + ((w.am + w.pbq + (w.cm >>> 17) + (p7 <<< 7)) >>> 4);
        pipe_next[LAST] = w;
    end

    // the pipeline moves as a whole while the skid register is free
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_comb begin
        res_d.temperature_centi = pipe_reg[LAST].temp;
        res_d.pressure_pa       = pipe_reg[LAST].pres;
        res_d.humidity_milli    = pipe_reg[LAST].hum;
        res_d.gas_ohms          = $signed(pipe_reg[LAST].gohm);
        res_d.gas_valid_out     = pipe_reg[LAST].gv;
        res_d.heater_stable_out = pipe_reg[LAST].hs;
    end

    // output register plus skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (vld_reg[LAST]) begin
                out_reg <= res_d;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (adv && vld_reg[LAST]) begin
            if (!out_valid_reg) begin
                out_reg       <= res_d;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res_d;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_temperature_centi = out_reg.temperature_centi;
    assign m_pressure_pa       = out_reg.pressure_pa;
    assign m_humidity_milli    = out_reg.humidity_milli;
    assign m_gas_ohms          = out_reg.gas_ohms;
    assign m_gas_valid_out     = out_reg.gas_valid_out;
    assign m_heater_stable_out = out_reg.heater_stable_out;

    // checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction while output register is empty");

    a_gas_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_POST-1] |-> (pipe_reg[ST_POST-1].grem < pipe_reg[ST_POST-1].g2))
        else $error("gas divider remainder not below divisor");

    a_gas_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAST] && !pipe_reg[LAST].gon) |->
            (pipe_reg[LAST].gohm == '0 && !pipe_reg[LAST].gv && !pipe_reg[LAST].hs))
        else $error("gas result not cleared with gas disabled");

endmodule
